// File: src/psd_pkg.sv
// ----------------------------------------------------------------------------
// psd_pkg: shared types and constants for the PSK symbol derotate and pack
// block. It holds the modulation codes, register indexes and queue entry type.
// ----------------------------------------------------------------------------
package psd_pkg;

  localparam int MAX_FRAME_BYTES_DEF = 256;
  localparam int QUEUE_DEPTH_DEF     = 2;

  localparam int SYM_W      = 3;
  localparam int BYTE_W     = 8;
  localparam int ACC_W      = 10;
  localparam int BITCNT_W   = 4;
  localparam int NBITS_W    = 2;
  localparam int STEPS_W    = 3;
  localparam int FRAME_W    = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  typedef enum logic [1:0] {
    MODE_BPSK = 2'd0,
    MODE_QPSK = 2'd1,
    MODE_8PSK = 2'd2,
    MODE_NONE = 2'd3
  } psd_mode_t;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_STEPS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_FRAME = 2'd2;

  localparam logic [FRAME_W-1:0] FRAME_RESET = 9'd256;

  typedef struct packed {
    logic [NBITS_W-1:0] nbits;
    logic [SYM_W-1:0]   bits;
  } psd_sym_t;

endpackage

// File: src/psd_front.sv
// ----------------------------------------------------------------------------
// psd_front: input stage
// Derotates each accepted symbol for the current mode and forms a queue entry
// with the bit count. Symbols in the unused mode are taken and dropped.
// ----------------------------------------------------------------------------
module psd_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [psd_pkg::SYM_W-1:0]        in_symbol,
  input  psd_pkg::psd_mode_t               mode,
  input  logic [psd_pkg::STEPS_W-1:0]      steps,
  input  logic                             q_full,
  output logic                             q_push,
  output psd_pkg::psd_sym_t                q_wdata
);

  logic       bpsk_bit;
  logic [1:0] qpsk_sym;
  logic [2:0] epsk_sym;

  assign in_ready = !q_full;

  assign bpsk_bit = in_symbol[0] ^ (steps == 3'd1);
  assign qpsk_sym = in_symbol[1:0] - steps[1:0];
  assign epsk_sym = in_symbol - steps;

  always_comb begin
    q_wdata.nbits = 2'd0;
    q_wdata.bits  = 3'd0;
    case (mode)
      psd_pkg::MODE_BPSK: begin
        q_wdata.nbits = 2'd1;
        q_wdata.bits  = {2'b00, bpsk_bit};
      end
      psd_pkg::MODE_QPSK: begin
        q_wdata.nbits = 2'd2;
        q_wdata.bits  = {1'b0, qpsk_sym};
      end
      psd_pkg::MODE_8PSK: begin
        q_wdata.nbits = 2'd3;
        q_wdata.bits  = epsk_sym;
      end
      default: begin
        q_wdata.nbits = 2'd0;
        q_wdata.bits  = 3'd0;
      end
    endcase
  end

  assign q_push = in_valid && in_ready && (mode != psd_pkg::MODE_NONE);

  property p_push_has_bits;
    @(posedge clk) disable iff (!rst_n) q_push |-> (q_wdata.nbits != 2'd0);
  endproperty
  a_push_has_bits: assert property (p_push_has_bits)
    else $error("psd_front: queue entry without bits");

endmodule

// File: src/psd_fifo.sv
// ----------------------------------------------------------------------------
// psd_fifo: short queue between the input and packing stages
// Register based first-in first-out queue with a fill count.
// ----------------------------------------------------------------------------
module psd_fifo #(
  parameter int DEPTH = psd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  psd_pkg::psd_sym_t wdata,
  output logic              full,
  input  logic              pop,
  output logic              rvalid,
  output psd_pkg::psd_sym_t rdata
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  psd_pkg::psd_sym_t  mem_r [DEPTH];
  logic [PTR_W-1:0]   wptr_r, wptr_nxt;
  logic [PTR_W-1:0]   rptr_r, rptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign rvalid  = (cnt_r != '0);
  assign rdata   = mem_r[rptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && rvalid;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PTR_W'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PTR_W'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

  property p_no_push_full;
    @(posedge clk) disable iff (!rst_n) !(push && full);
  endproperty
  a_no_push_full: assert property (p_no_push_full)
    else $error("psd_fifo: push into a full queue");

  property p_cnt_bound;
    @(posedge clk) disable iff (!rst_n) cnt_r <= CNT_W'(DEPTH);
  endproperty
  a_cnt_bound: assert property (p_cnt_bound)
    else $error("psd_fifo: fill count out of range");

endmodule

// File: src/psd_back.sv
// ----------------------------------------------------------------------------
// psd_back: packing stage
// Shifts derotated symbols into the bit accumulator, emits completed bytes
// into the output register and marks the byte that ends a frame.
// ----------------------------------------------------------------------------
module psd_back #(
  parameter int MAX_FRAME_BYTES = psd_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_valid,
  input  psd_pkg::psd_sym_t              q_rdata,
  output logic                           q_pop,
  input  logic [psd_pkg::FRAME_W-1:0]    frame_bytes,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [psd_pkg::BYTE_W-1:0]     out_data_byte,
  output logic                           out_last_byte
);

  localparam int CW = $clog2(MAX_FRAME_BYTES + 1);
  localparam int LW = (CW > psd_pkg::FRAME_W) ? CW : psd_pkg::FRAME_W;

  logic [psd_pkg::ACC_W-1:0]    acc_r, acc_nxt, acc_sh;
  logic [psd_pkg::BITCNT_W-1:0] bit_cnt_r, bit_cnt_nxt, bit_sum;
  logic [CW-1:0]                byte_cnt_r, byte_cnt_nxt, byte_cnt_inc;
  logic                         out_valid_r, out_valid_nxt;
  logic [psd_pkg::BYTE_W-1:0]   data_r, data_nxt, byte_val;
  logic                         last_r, last_nxt;
  logic [LW-1:0]                frame_ext, frame_len;
  logic                         advance, emit, is_last;

  assign out_valid     = out_valid_r;
  assign out_data_byte = data_r;
  assign out_last_byte = last_r;

  assign advance = q_valid && (!out_valid_r || out_ready);
  assign q_pop   = advance;

  assign frame_ext = LW'(frame_bytes);
  assign frame_len = ((frame_bytes == '0) || (frame_ext > LW'(MAX_FRAME_BYTES))) ?
                     LW'(MAX_FRAME_BYTES) : frame_ext;

  always_comb begin
    case (q_rdata.nbits)
      2'd1:    acc_sh = {acc_r[8:0], q_rdata.bits[0]};
      2'd2:    acc_sh = {acc_r[7:0], q_rdata.bits[1:0]};
      2'd3:    acc_sh = {acc_r[6:0], q_rdata.bits};
      default: acc_sh = acc_r;
    endcase
  end

  assign bit_sum      = bit_cnt_r + {2'b00, q_rdata.nbits};
  assign emit         = bit_sum[3];
  assign byte_cnt_inc = byte_cnt_r + 1'b1;
  assign is_last      = (LW'(byte_cnt_inc) >= frame_len);

  always_comb begin
    case (bit_sum[1:0])
      2'd1:    byte_val = acc_sh[8:1];
      2'd2:    byte_val = acc_sh[9:2];
      default: byte_val = acc_sh[7:0];
    endcase
  end

  always_comb begin
    acc_nxt       = acc_r;
    bit_cnt_nxt   = bit_cnt_r;
    byte_cnt_nxt  = byte_cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    data_nxt      = data_r;
    last_nxt      = last_r;
    if (advance) begin
      if (emit) begin
        out_valid_nxt = 1'b1;
        data_nxt      = byte_val;
        last_nxt      = is_last;
        if (is_last) begin
          acc_nxt      = '0;
          bit_cnt_nxt  = '0;
          byte_cnt_nxt = '0;
        end else begin
          bit_cnt_nxt  = {2'b00, bit_sum[1:0]};
          byte_cnt_nxt = byte_cnt_inc;
          case (bit_sum[1:0])
            2'd1:    acc_nxt = {9'd0, acc_sh[0]};
            2'd2:    acc_nxt = {8'd0, acc_sh[1:0]};
            default: acc_nxt = '0;
          endcase
        end
      end else begin
        acc_nxt     = acc_sh;
        bit_cnt_nxt = bit_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      bit_cnt_r   <= '0;
      byte_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      byte_cnt_r  <= byte_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    last_r <= last_nxt;
  end

  property p_bitcnt_bound;
    @(posedge clk) disable iff (!rst_n) bit_cnt_r < 4'd8;
  endproperty
  a_bitcnt_bound: assert property (p_bitcnt_bound)
    else $error("psd_back: bit count reached a full byte");

  property p_last_clears;
    @(posedge clk) disable iff (!rst_n)
      (advance && emit && is_last) |=> (byte_cnt_r == '0 && bit_cnt_r == '0 && out_last_byte);
  endproperty
  a_last_clears: assert property (p_last_clears)
    else $error("psd_back: frame end did not clear the counters");

endmodule

// File: src/psk_symbol_derotate_pack.sv
// Path: a symbol accepted at the input is written into the queue, the packing
// stage then shifts it into the accumulator, and the byte it completes is
// loaded into the output register, raises out_valid and waits for out_ready.
// Throughput: one symbol per cycle while out_ready is high; a byte leaves every 8,
// 4 or about 2.7 symbols for BPSK, QPSK and 8PSK, by each mode's bits per symbol.
// Reset (synchronous, active low) empties the queue, clears the accumulator
// and counters, and loads mode QPSK, zero rotation and a 256-byte frame.
// ----------------------------------------------------------------------------
// psk_symbol_derotate_pack: receive-side PSK demapper
// Derotates received symbols and packs their bits MSB-first into bytes,
// marking the last byte of each frame.
// ----------------------------------------------------------------------------
module psk_symbol_derotate_pack #(
  parameter int MAX_FRAME_BYTES = psd_pkg::MAX_FRAME_BYTES_DEF,
  parameter int QUEUE_DEPTH     = psd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [psd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [psd_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [psd_pkg::SYM_W-1:0]         in_symbol,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [psd_pkg::BYTE_W-1:0]        out_data_byte,
  output logic                              out_last_byte
);

  psd_pkg::psd_mode_t              mode_r, mode_nxt;
  logic [psd_pkg::STEPS_W-1:0]     steps_r, steps_nxt;
  logic [psd_pkg::FRAME_W-1:0]     frame_r, frame_nxt;

  logic                            q_full, q_push, q_pop, q_valid;
  psd_pkg::psd_sym_t               q_wdata, q_rdata;

  always_comb begin
    mode_nxt  = mode_r;
    steps_nxt = steps_r;
    frame_nxt = frame_r;
    if (cfg_we) begin
      case (cfg_index)
        psd_pkg::CFG_IDX_MODE:  mode_nxt  = psd_pkg::psd_mode_t'(cfg_wdata[1:0]);
        psd_pkg::CFG_IDX_STEPS: steps_nxt = cfg_wdata[psd_pkg::STEPS_W-1:0];
        psd_pkg::CFG_IDX_FRAME: frame_nxt = cfg_wdata[psd_pkg::FRAME_W-1:0];
        default: begin
          mode_nxt = mode_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= psd_pkg::MODE_QPSK;
      steps_r <= '0;
      frame_r <= psd_pkg::FRAME_RESET;
    end else begin
      mode_r  <= mode_nxt;
      steps_r <= steps_nxt;
      frame_r <= frame_nxt;
    end
  end

  psd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_symbol (in_symbol),
    .mode      (mode_r),
    .steps     (steps_r),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  psd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .full   (q_full),
    .pop    (q_pop),
    .rvalid (q_valid),
    .rdata  (q_rdata)
  );

  psd_back #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_rdata       (q_rdata),
    .q_pop         (q_pop),
    .frame_bytes   (frame_r),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data_byte (out_data_byte),
    .out_last_byte (out_last_byte)
  );

endmodule
